// ===== rtl/core/izt_pkg.sv =====
// Package for the ignore-zone text loader and mask unit.
// Holds shared constants, codes and the parser/control struct types.
// No dependencies.
package izt_pkg;

  localparam int unsigned MAX_ZONES_DEF = 8;
  localparam int unsigned ZONE_W        = 64;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned ACC_W         = 17;
  localparam int unsigned CNT_OUT_W     = 4;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] ACC_SAT         = 17'h10000;
  localparam logic [2:0]       FIELDS_PER_ZONE = 3'd4;

  localparam logic REQ_TEXT   = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [ZONE_W-1:0] gf;
    logic [ACC_W-1:0]  acc;
    logic [2:0]        fd;
    logic              hd;
    logic              ne;
    logic              err;
  } parse_t;

  typedef struct packed {
    logic push;
    logic fin;
    logic ok;
  } ctl_t;

endpackage

// ===== rtl/core/izt_cell.sv =====
// One zone cell: staged and active rectangle, shift link and hit chain link.
// Depends on izt_pkg.
module izt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 4
) (
  input  logic                        clk_i,
  input  logic                        shift_i,
  input  logic                        commit_i,
  input  logic [izt_pkg::ZONE_W-1:0]  zone_i,
  output logic [izt_pkg::ZONE_W-1:0]  zone_o,
  input  logic [CW-1:0]               active_count_i,
  input  logic [izt_pkg::COORD_W-1:0] pixel_x_i,
  input  logic [izt_pkg::COORD_W-1:0] pixel_y_i,
  input  logic                        hit_i,
  output logic                        hit_o
);

  logic [izt_pkg::ZONE_W-1:0]  staged_q, staged_d;
  logic [izt_pkg::ZONE_W-1:0]  active_q, active_d;
  logic [izt_pkg::COORD_W-1:0] zx, zy, zw, zh;
  logic [izt_pkg::COORD_W:0]   x_end, y_end;
  logic                        in_rect;
  logic                        live;

  assign staged_d = shift_i ? zone_i : staged_q;
  assign active_d = commit_i ? staged_d : active_q;
  assign zone_o   = staged_q;

  always_ff @(posedge clk_i) begin
    staged_q <= staged_d;
    active_q <= active_d;
  end

  assign zx    = active_q[15:0];
  assign zy    = active_q[31:16];
  assign zw    = active_q[47:32];
  assign zh    = active_q[63:48];
  assign x_end = {1'b0, zx} + {1'b0, zw};
  assign y_end = {1'b0, zy} + {1'b0, zh};

  assign in_rect = (pixel_x_i >= zx) && (pixel_y_i >= zy) &&
                   ({1'b0, pixel_x_i} < x_end) && ({1'b0, pixel_y_i} < y_end);
  assign live    = CW'(IDX) < active_count_i;
  assign hit_o   = hit_i | (live & in_rect);

endmodule

// ===== rtl/core/izt_parse.sv =====
// Zone list text parser: field and group state, staged count, push and commit control.
// Depends on izt_pkg.
module izt_parse #(
  parameter int unsigned MAX_ZONES = izt_pkg::MAX_ZONES_DEF,
  parameter int unsigned CW        = $clog2(MAX_ZONES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       char_valid_i,
  input  logic [7:0]                 text_char_i,
  input  logic                       text_last_i,
  output izt_pkg::ctl_t              ctl_o,
  output logic [izt_pkg::ZONE_W-1:0] zone_o,
  output logic [CW-1:0]              stage_cnt_o
);

  izt_pkg::parse_t state_q, state_d;
  izt_pkg::parse_t s;
  logic [CW-1:0]   cnt_q, cnt_d, cnt_n;
  logic [19:0]     acc_next;
  logic            is_semi, is_comma, is_digit;
  logic            fin, push;
  logic [izt_pkg::ZONE_W-1:0] zone;

  function automatic izt_pkg::parse_t finish_field(izt_pkg::parse_t f);
    izt_pkg::parse_t r;
    r = f;
    if (!f.hd || f.acc[izt_pkg::ACC_W-1] || (f.fd >= izt_pkg::FIELDS_PER_ZONE)) begin
      r.err = 1'b1;
    end else begin
      r.gf[{f.fd[1:0], 4'b0000} +: izt_pkg::COORD_W] = f.acc[izt_pkg::COORD_W-1:0];
      r.fd = 3'(f.fd + 3'd1);
    end
    r.acc = '0;
    r.hd  = 1'b0;
    return r;
  endfunction

  assign is_semi  = text_char_i == izt_pkg::CHAR_SEMI;
  assign is_comma = text_char_i == izt_pkg::CHAR_COMMA;
  assign is_digit = (text_char_i >= izt_pkg::CHAR_ZERO) && (text_char_i <= izt_pkg::CHAR_NINE);
  assign acc_next = 20'(state_q.acc) * 20'd10 + 20'(text_char_i - izt_pkg::CHAR_ZERO);

  always_comb begin
    s    = state_q;
    push = 1'b0;
    zone = '0;
    if (char_valid_i && !is_semi) begin
      s.ne = 1'b1;
      if (is_comma) begin
        s = finish_field(s);
      end else if (is_digit) begin
        s.hd  = 1'b1;
        s.acc = (acc_next > 20'(izt_pkg::ACC_SAT)) ? izt_pkg::ACC_SAT
                                                   : acc_next[izt_pkg::ACC_W-1:0];
      end else begin
        s.err = 1'b1;
      end
    end
    fin = (char_valid_i && is_semi) || text_last_i;
    if (fin) begin
      if (s.ne) begin
        s    = finish_field(s);
        zone = s.gf;
        if (s.fd != izt_pkg::FIELDS_PER_ZONE) begin
          s.err = 1'b1;
        end else if (!s.err) begin
          if (cnt_q >= CW'(MAX_ZONES)) begin
            s.err = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
      end
      s.gf  = '0;
      s.acc = '0;
      s.fd  = '0;
      s.hd  = 1'b0;
      s.ne  = 1'b0;
    end
    cnt_n = cnt_q + CW'(push);

    state_d = state_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      state_d = text_last_i ? '0 : s;
      cnt_d   = text_last_i ? '0 : cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctl_o.push  = step_i & push;
  assign ctl_o.fin   = step_i & text_last_i;
  assign ctl_o.ok    = ~s.err;
  assign zone_o      = zone;
  assign stage_cnt_o = cnt_n;

endmodule

// ===== rtl/core/ignore_zone_text_loader_and_mask_unit.sv =====
// Top level of the ignore-zone text loader and mask unit.
// Depends on izt_pkg, izt_parse and izt_cell.
//
// Takes one item per cycle: either a character of a zone list ("x,y,w,h;..." in
// decimal) or a pixel query. Each item is handled in the cycle it is accepted;
// its result, if any, appears in the output register on the next cycle. A
// character item marked last returns the load status; a query returns whether
// the pixel falls inside any active zone. Zones live in a row of MAX_ZONES
// cells: each good group within capacity shifts into the first cell, a good load copies
// every staged zone to its active slot at once, and the query hit runs along
// the row as an OR chain. The input stalls only while a result waits unread.
module ignore_zone_text_loader_and_mask_unit #(
  parameter int unsigned MAX_ZONES = izt_pkg::MAX_ZONES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic                        char_valid_i,
  input  logic [7:0]                  text_char_i,
  input  logic                        text_last_i,
  input  logic [izt_pkg::COORD_W-1:0] pixel_x_i,
  input  logic [izt_pkg::COORD_W-1:0] pixel_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic                        load_ok_o,
  output logic                        pixel_ignored_o,
  output logic [izt_pkg::CNT_OUT_W-1:0] zones_in_use_o
);

  localparam int unsigned CW = $clog2(MAX_ZONES + 1);

  izt_pkg::ctl_t              ctl;
  logic [izt_pkg::ZONE_W-1:0] push_zone;
  logic [CW-1:0]              stage_cnt;
  logic [CW-1:0]              active_count_q, active_count_d;
  logic                       fire, step, query, commit, emit;
  logic [izt_pkg::ZONE_W-1:0] zone_chain [MAX_ZONES+1];
  logic                       hit_chain  [MAX_ZONES+1];

  logic                          out_valid_q, out_valid_d;
  logic                          result_kind_q, result_kind_d;
  logic                          load_ok_q, load_ok_d;
  logic                          pixel_ignored_q, pixel_ignored_d;
  logic [izt_pkg::CNT_OUT_W-1:0] zones_q, zones_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;
  assign query      = req_type_i == izt_pkg::REQ_QUERY;
  assign step       = fire & ~query;
  assign commit     = ctl.fin & ctl.ok;
  assign emit       = fire & (query | text_last_i);

  izt_parse #(
    .MAX_ZONES(MAX_ZONES),
    .CW       (CW)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_valid_i(char_valid_i),
    .text_char_i (text_char_i),
    .text_last_i (text_last_i),
    .ctl_o       (ctl),
    .zone_o      (push_zone),
    .stage_cnt_o (stage_cnt)
  );

  assign zone_chain[0] = push_zone;
  assign hit_chain[0]  = 1'b0;

  for (genvar i = 0; i < MAX_ZONES; i++) begin : g_cell
    izt_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .shift_i       (ctl.push),
      .commit_i      (commit),
      .zone_i        (zone_chain[i]),
      .zone_o        (zone_chain[i+1]),
      .active_count_i(active_count_q),
      .pixel_x_i     (pixel_x_i),
      .pixel_y_i     (pixel_y_i),
      .hit_i         (hit_chain[i]),
      .hit_o         (hit_chain[i+1])
    );
  end

  always_comb begin
    active_count_d  = commit ? stage_cnt : active_count_q;
    out_valid_d     = out_valid_q & out_stall_i;
    result_kind_d   = result_kind_q;
    load_ok_d       = load_ok_q;
    pixel_ignored_d = pixel_ignored_q;
    zones_d         = zones_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (query) begin
        result_kind_d   = izt_pkg::KIND_QUERY;
        load_ok_d       = 1'b0;
        pixel_ignored_d = hit_chain[MAX_ZONES];
        zones_d         = izt_pkg::CNT_OUT_W'(active_count_q);
      end else begin
        result_kind_d   = izt_pkg::KIND_LOAD;
        load_ok_d       = ctl.ok;
        pixel_ignored_d = 1'b0;
        zones_d         = izt_pkg::CNT_OUT_W'(active_count_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      active_count_q <= active_count_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_kind_q   <= result_kind_d;
    load_ok_q       <= load_ok_d;
    pixel_ignored_q <= pixel_ignored_d;
    zones_q         <= zones_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = result_kind_q;
  assign load_ok_o       = load_ok_q;
  assign pixel_ignored_o = pixel_ignored_q;
  assign zones_in_use_o  = zones_q;

  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && query |=> out_valid_q && (result_kind_q == izt_pkg::KIND_QUERY) && !load_ok_q)
    else $error("query item did not produce a query result");

  a_failed_load_keeps_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fin && !ctl.ok |=> $stable(active_count_q))
    else $error("failed load changed the active zone count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_count_q <= CW'(MAX_ZONES))
    else $error("active zone count above capacity");

  a_load_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_kind_q == izt_pkg::KIND_LOAD) |-> !pixel_ignored_q)
    else $error("load status carries a pixel hit");

endmodule

// ===== test/tb.sv =====
// Testbench for the ignore-zone text loader and mask unit: a directed table of
// zone lists and pixel queries, then random lists with queries mixed in.
// Depends on izt_pkg and ignore_zone_text_loader_and_mask_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NZ          = izt_pkg::MAX_ZONES_DEF;
  localparam int unsigned ITEM_TARGET = 750;

  typedef struct packed {
    logic        req;
    logic        cv;
    logic [7:0]  ch;
    logic        last;
    logic [15:0] px;
    logic [15:0] py;
  } mask_item_t;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic       hit;
    logic [3:0] cnt;
  } mask_result_t;

  typedef enum {ROW_TEXT, ROW_QUERY, ROW_IDLE} row_kind_e;
  typedef enum {END_ON_CHAR, END_SEPARATE, END_NONE} end_mode_e;

  typedef struct {
    row_kind_e    kind;
    string        text;
    int           reps;
    end_mode_e    fin;
    logic [15:0]  px;
    logic [15:0]  py;
    bit           typed;
    mask_result_t res;
  } row_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          req_type_i   = 1'b0;
  logic                          char_valid_i = 1'b0;
  logic [7:0]                    text_char_i  = '0;
  logic                          text_last_i  = 1'b0;
  logic [izt_pkg::COORD_W-1:0]   pixel_x_i    = '0;
  logic [izt_pkg::COORD_W-1:0]   pixel_y_i    = '0;
  logic                          out_stall_i  = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          result_kind_o;
  logic                          load_ok_o;
  logic                          pixel_ignored_o;
  logic [izt_pkg::CNT_OUT_W-1:0] zones_in_use_o;

  ignore_zone_text_loader_and_mask_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .char_valid_i   (char_valid_i),
    .text_char_i    (text_char_i),
    .text_last_i    (text_last_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .load_ok_o      (load_ok_o),
    .pixel_ignored_o(pixel_ignored_o),
    .zones_in_use_o (zones_in_use_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [63:0]  live_tbl  [NZ];
  int unsigned  live_cnt  = 0;
  logic [63:0]  stage_tbl [NZ];
  int unsigned  stage_cnt = 0;
  logic [63:0]  grp_fields = '0;
  logic [16:0]  acc        = '0;
  int unsigned  nfields    = 0;
  bit           has_digit  = 1'b0;
  bit           grp_open   = 1'b0;
  bit           parse_err  = 1'b0;

  mask_result_t pending_results[$];
  logic [7:0]   text_q[$];
  row_t         plan[$];
  int           mismatches = 0;
  int           items_sent = 0;
  bit           calm       = 1'b0;
  int           hold_left  = 0;

  function automatic void clear_group_state();
    grp_fields = '0;
    acc        = '0;
    nfields    = 0;
    has_digit  = 1'b0;
    grp_open   = 1'b0;
  endfunction

  function automatic void field_close();
    if (!has_digit || acc >= izt_pkg::ACC_SAT || nfields >= izt_pkg::FIELDS_PER_ZONE) begin
      parse_err = 1'b1;
    end else begin
      grp_fields |= 64'(acc[15:0]) << (16 * nfields);
      nfields++;
    end
    acc       = '0;
    has_digit = 1'b0;
  endfunction

  function automatic void group_close();
    if (grp_open) begin
      field_close();
      if (nfields != izt_pkg::FIELDS_PER_ZONE) begin
        parse_err = 1'b1;
      end else if (!parse_err) begin
        if (stage_cnt >= NZ) begin
          parse_err = 1'b1;
        end else begin
          stage_tbl[stage_cnt] = grp_fields;
          stage_cnt++;
        end
      end
    end
    clear_group_state();
  endfunction

  function automatic bit mask_step(input mask_item_t it, output mask_result_t r);
    logic [15:0] zx, zy, zw, zh;
    int          v;
    r = '0;
    if (it.req == izt_pkg::REQ_QUERY) begin
      r.kind = izt_pkg::KIND_QUERY;
      for (int i = 0; i < live_cnt; i++) begin
        {zh, zw, zy, zx} = live_tbl[i];
        if (it.px >= zx && it.py >= zy && 17'(it.px) < 17'(zx) + 17'(zw) &&
            17'(it.py) < 17'(zy) + 17'(zh)) begin
          r.hit = 1'b1;
        end
      end
      r.cnt = 4'(live_cnt);
      return 1'b1;
    end
    if (it.cv) begin
      if (it.ch == izt_pkg::CHAR_SEMI) begin
        group_close();
      end else if (it.ch == izt_pkg::CHAR_COMMA) begin
        grp_open = 1'b1;
        field_close();
      end else if (it.ch >= izt_pkg::CHAR_ZERO && it.ch <= izt_pkg::CHAR_NINE) begin
        grp_open  = 1'b1;
        has_digit = 1'b1;
        v   = int'(acc) * 10 + int'(it.ch - izt_pkg::CHAR_ZERO);
        acc = (v > int'(izt_pkg::ACC_SAT)) ? izt_pkg::ACC_SAT : 17'(v);
      end else begin
        grp_open  = 1'b1;
        parse_err = 1'b1;
      end
    end
    if (!it.last) return 1'b0;
    group_close();
    r.kind = izt_pkg::KIND_LOAD;
    r.ok   = !parse_err;
    if (!parse_err) begin
      live_tbl = stage_tbl;
      live_cnt = stage_cnt;
    end
    r.cnt     = 4'(live_cnt);
    stage_cnt = 0;
    parse_err = 1'b0;
    clear_group_state();
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] near_bound(logic [15:0] span);
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return span - 16'd1;
      3: return span;
      4: return span + 16'd1;
      default: return 16'($urandom_range(0, span));
    endcase
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.insert(text_q.size(), s[i]);
  endfunction

  function automatic mask_result_t mk_res(logic kind, logic ok, logic hit, int cnt);
    mask_result_t r;
    r = '{kind, ok, hit, 4'(cnt)};
    return r;
  endfunction

  function automatic row_t mk_row(row_kind_e kind, string text, int reps, end_mode_e fin,
                                  int px, int py, bit typed, mask_result_t res);
    row_t r;
    r.kind  = kind;
    r.text  = text;
    r.reps  = reps;
    r.fin   = fin;
    r.px    = 16'(px);
    r.py    = 16'(py);
    r.typed = typed;
    r.res   = res;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    plan.insert(plan.size(), r);
  endfunction

  task automatic flag_error(string msg);
    if (mismatches < 100) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic drive_item(input mask_item_t it, input bit typed, input mask_result_t want);
    int           gap;
    mask_result_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {req_type_i, char_valid_i, text_char_i, text_last_i, pixel_x_i, pixel_y_i} <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mask_step(it, r)) pending_results.insert(pending_results.size(), typed ? want : r);
    if (it.req == izt_pkg::REQ_QUERY || it.cv || it.last) items_sent++;
  endtask

  task automatic mix_in_noise(int pct);
    mask_item_t  it;
    logic [63:0] raw;
    logic [15:0] zx, zy, zw, zh;
    int          p;
    p = $urandom_range(0, 99);
    if (p >= pct) return;
    raw = {$urandom, $urandom};
    it  = raw[$bits(mask_item_t)-1:0];
    if (p < pct / 8) begin
      it.req  = izt_pkg::REQ_TEXT;
      it.cv   = 1'b0;
      it.last = 1'b0;
    end else begin
      it.req = izt_pkg::REQ_QUERY;
      if (live_cnt > 0 && $urandom_range(0, 9) < 7) begin
        {zh, zw, zy, zx} = live_tbl[$urandom_range(0, live_cnt - 1)];
        it.px = zx + near_bound(zw);
        it.py = zy + near_bound(zh);
      end else if ($urandom_range(0, 1)) begin
        it.px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        it.py = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    end
    drive_item(it, 1'b0, '0);
  endtask

  task automatic send_text(input end_mode_e fin, input bit mix, input bit typed,
                           input mask_result_t want);
    mask_item_t  it;
    logic [63:0] raw;
    int          n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      if (mix) mix_in_noise(25);
      raw     = {$urandom, $urandom};
      it      = raw[$bits(mask_item_t)-1:0];
      it.req  = izt_pkg::REQ_TEXT;
      it.cv   = 1'b1;
      it.ch   = text_q[i];
      it.last = (fin == END_ON_CHAR && i == n - 1);
      drive_item(it, typed && it.last, want);
    end
    if (fin == END_SEPARATE || (fin == END_ON_CHAR && n == 0)) begin
      raw     = {$urandom, $urandom};
      it      = raw[$bits(mask_item_t)-1:0];
      it.req  = izt_pkg::REQ_TEXT;
      it.cv   = 1'b0;
      it.last = 1'b1;
      drive_item(it, typed, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left == 0) hold_left = idle_len();
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    mask_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result kind %0d with nothing pending", result_kind_o));
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind)
          flag_error($sformatf("result_kind %0d, want %0d", result_kind_o, want.kind));
        if (load_ok_o !== want.ok)
          flag_error($sformatf("load_ok %0d, want %0d", load_ok_o, want.ok));
        if (pixel_ignored_o !== want.hit)
          flag_error($sformatf("pixel_ignored %0d, want %0d", pixel_ignored_o, want.hit));
        if (zones_in_use_o !== want.cnt)
          flag_error($sformatf("zones_in_use %0d, want %0d", zones_in_use_o, want.cnt));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mask_item_t  it;
    logic [63:0] raw;
    logic [7:0]  b;
    string       s;
    end_mode_e   fin;
    bit          broken;
    int          p, v, ngroups, nf, flaw, flaw_at;

    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_QUERY, 0, 0, 0)));
    add_row(mk_row(ROW_TEXT, "", 1, END_SEPARATE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 1, 0, 0)));
    add_row(mk_row(ROW_IDLE, "", 0, END_NONE, 0, 0, 0, '0));
    add_row(mk_row(ROW_TEXT, "65535,65535,65535,65535", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 1, 0, 1)));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 65535, 65535, 1,
                   mk_res(izt_pkg::KIND_QUERY, 0, 1, 1)));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_QUERY, 0, 0, 1)));
    add_row(mk_row(ROW_TEXT, ";;0,0,10,10;;5,5,1,1;", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 1, 0, 2)));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 9, 9, 0, '0));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 10, 5, 0, '0));
    add_row(mk_row(ROW_TEXT, "65536,0,1,1", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "999999,0,1,1", 1, END_SEPARATE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "1,,1,1", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "1,2,3", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "1,2,3,4,5;", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "-1,2,3,4", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "1,2 ,3,4", 1, END_SEPARATE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "7\377,1,1,1", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "0,0,1,1;", NZ + 1, END_SEPARATE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 0, 0, 2)));
    add_row(mk_row(ROW_TEXT, "0,0,1,1;", NZ, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 1, 0, NZ)));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 0, 0, 1,
                   mk_res(izt_pkg::KIND_QUERY, 0, 1, NZ)));
    add_row(mk_row(ROW_TEXT, "3,3,", 1, END_NONE, 0, 0, 0, '0));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 3, 3, 0, '0));
    add_row(mk_row(ROW_TEXT, "2,2", 1, END_ON_CHAR, 0, 0, 0, '0));
    add_row(mk_row(ROW_QUERY, "", 0, END_NONE, 4, 4, 0, '0));
    add_row(mk_row(ROW_TEXT, ";", 1, END_ON_CHAR, 0, 0, 1,
                   mk_res(izt_pkg::KIND_LOAD, 1, 0, 0)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      case (plan[k].kind)
        ROW_TEXT: begin
          text_q.delete();
          repeat (plan[k].reps) put_str(plan[k].text);
          send_text(plan[k].fin, 1'b0, plan[k].typed, plan[k].res);
        end
        ROW_QUERY: begin
          raw    = {$urandom, $urandom};
          it     = raw[$bits(mask_item_t)-1:0];
          it.req = izt_pkg::REQ_QUERY;
          it.px  = plan[k].px;
          it.py  = plan[k].py;
          drive_item(it, plan[k].typed, plan[k].res);
        end
        default: begin
          raw     = {$urandom, $urandom};
          it      = raw[$bits(mask_item_t)-1:0];
          it.req  = izt_pkg::REQ_TEXT;
          it.cv   = 1'b0;
          it.last = 1'b0;
          drive_item(it, 1'b0, '0);
        end
      endcase
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      text_q.delete();
      broken  = ($urandom_range(0, 99) < 20);
      p       = $urandom_range(0, 99);
      ngroups = (p < 6) ? 0 : (p < 16) ? NZ + 1 : (p < 26) ? NZ : $urandom_range(1, 4);
      flaw_at = broken ? $urandom_range(0, ngroups * 4) : -1;
      flaw    = $urandom_range(0, 4);
      if (ngroups == 0 && $urandom_range(0, 1)) put_str(";");
      for (int g = 0; g < ngroups; g++) begin
        if ($urandom_range(0, 9) == 0) put_str(";");
        nf = 4;
        if (g * 4 == flaw_at && flaw == 0) nf = $urandom_range(0, 1) ? 3 : 5;
        for (int f = 0; f < nf; f++) begin
          if (f > 0) put_str(",");
          if (g * 4 + f == flaw_at && flaw == 1) continue;
          p = $urandom_range(0, 99);
          v = (p < 35) ? $urandom_range(0, 15) : (p < 55) ? $urandom_range(0, 400) :
              (p < 62) ? 65535 : (p < 67) ? 0 : $urandom_range(0, 65535);
          if (g * 4 + f == flaw_at && flaw == 2) v = $urandom_range(65536, 999999);
          s = $sformatf("%0d", v);
          if ($urandom_range(0, 7) == 0) s = {"00", s};
          put_str(s);
          if (g * 4 + f == flaw_at && flaw == 3) begin
            do b = 8'($urandom); while (b >= izt_pkg::CHAR_ZERO && b <= izt_pkg::CHAR_NINE);
            text_q.insert(text_q.size() - $urandom_range(0, s.len()), b);
          end
        end
        if (g < ngroups - 1 || $urandom_range(0, 1)) put_str(";");
      end
      if (broken && flaw == 4) text_q.insert($urandom_range(0, text_q.size()), 8'($urandom));
      fin = $urandom_range(0, 1) ? END_ON_CHAR : END_SEPARATE;
      send_text(fin, 1'b1, 1'b0, '0);
      repeat ($urandom_range(0, 3)) mix_in_noise(70);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/izt_pkg.sv
rtl/core/izt_cell.sv
rtl/core/izt_parse.sv
rtl/core/ignore_zone_text_loader_and_mask_unit.sv
test/tb.sv
